[hw/rtl/atilt_pkg.sv]
`timescale 1ns / 1ps
// atilt_pkg: shared widths, lane types and arctangent table for the tilt angle unit
package atilt_pkg;

  localparam int IN_W        = 16;
  localparam int ROLL_W      = 17;
  localparam int YAW_W       = 16;
  localparam int ACC_FRAC    = 24;
  localparam int TABLE_LEN   = 24;
  localparam int PRESCALE_SH = 16;
  localparam int XY_W        = 36;
  localparam int ACC_W       = 35;
  localparam int NLANE       = 3;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  typedef logic signed [IN_W-1:0]  sample_t;
  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    xy_t  x;
    xy_t  y;
    acc_t acc;
    logic zero;
  } lane_t;

  typedef lane_t [NLANE-1:0] lanes_t;

  // atan(2^-i) in nanodegrees
  function automatic longint atan_nanodeg(int i);
    longint n;
    unique case (i)
      0:       n = 64'sd45000000000;
      1:       n = 64'sd26565051177;
      2:       n = 64'sd14036243468;
      3:       n = 64'sd7125016349;
      4:       n = 64'sd3576334375;
      5:       n = 64'sd1789910608;
      6:       n = 64'sd895173710;
      7:       n = 64'sd447614171;
      8:       n = 64'sd223810500;
      9:       n = 64'sd111905677;
      10:      n = 64'sd55952892;
      11:      n = 64'sd27976453;
      12:      n = 64'sd13988227;
      13:      n = 64'sd6994114;
      14:      n = 64'sd3497057;
      15:      n = 64'sd1748528;
      16:      n = 64'sd874264;
      17:      n = 64'sd437132;
      18:      n = 64'sd218566;
      19:      n = 64'sd109283;
      20:      n = 64'sd54642;
      21:      n = 64'sd27321;
      22:      n = 64'sd13660;
      23:      n = 64'sd6830;
      default: n = 64'sd0;
    endcase
    return n;
  endfunction

  // table entry in 2^-24 degree, rounded
  function automatic acc_t atan_units(int i);
    longint n;
    n = atan_nanodeg(i);
    return acc_t'((n * 64'sd16777216 + 64'sd500000000) / 64'sd1000000000);
  endfunction

  function automatic acc_t deg_units(int d);
    return acc_t'(longint'(d) * 64'sd16777216);
  endfunction

endpackage

[hw/rtl/atilt_if.sv]
`timescale 1ns / 1ps
// atilt_in_if / atilt_out_if: sample and angle channels with valid/ready
interface atilt_in_if;
  import atilt_pkg::*;
  logic    valid;
  logic    ready;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;
  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface atilt_out_if;
  import atilt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ROLL_W-1:0] roll_angle;
  logic signed [ROLL_W-1:0] pitch_angle;
  logic signed [YAW_W-1:0]  yaw_angle;
  modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                  output ready);
endinterface

[hw/rtl/atilt_prep.sv]
`timescale 1ns / 1ps
// atilt_prep: operand scaling, half-plane fold and initial angle for the three lanes
module atilt_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  atilt_pkg::sample_t accel_x,
  input  atilt_pkg::sample_t accel_y,
  input  atilt_pkg::sample_t accel_z,
  output logic             dn_valid,
  input  logic             dn_ready,
  output atilt_pkg::lanes_t dn_lanes
);
  import atilt_pkg::*;

  localparam acc_t OFF_TILT = deg_units(-90);
  localparam acc_t OFF_YAW  = deg_units(0);
  localparam acc_t HALF_TURN = deg_units(180);

  logic   valid_r;
  lanes_t lanes_r;
  lanes_t lanes_nxt;
  logic   take;

  function automatic lane_t prep_lane(sample_t num, sample_t den, acc_t off);
    lane_t l;
    xy_t   xs;
    xy_t   ys;
    xs = xy_t'(den) <<< PRESCALE_SH;
    ys = xy_t'(num) <<< PRESCALE_SH;
    l.zero = (num == '0) && (den == '0);
    if (den < 0) begin
      l.x   = -xs;
      l.y   = -ys;
      l.acc = (num >= 0) ? off + HALF_TURN : off - HALF_TURN;
    end else begin
      l.x   = xs;
      l.y   = ys;
      l.acc = off;
    end
    return l;
  endfunction

  always_comb begin
    lanes_nxt[LANE_ROLL]  = prep_lane(accel_z, accel_x, OFF_TILT);
    lanes_nxt[LANE_PITCH] = prep_lane(accel_z, accel_y, OFF_TILT);
    lanes_nxt[LANE_YAW]   = prep_lane(accel_x, accel_y, OFF_YAW);
  end

  assign take     = !valid_r || dn_ready;
  assign up_ready = take;
  assign dn_valid = valid_r;
  assign dn_lanes = lanes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && up_valid) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

[hw/rtl/atilt_cell.sv]
`timescale 1ns / 1ps
// atilt_cell: one vectoring micro-rotation for all three lanes
module atilt_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  atilt_pkg::lanes_t up_lanes,
  output logic             dn_valid,
  input  logic             dn_ready,
  output atilt_pkg::lanes_t dn_lanes
);
  import atilt_pkg::*;

  localparam acc_t ANGLE = atan_units(STAGE);

  logic   valid_r;
  lanes_t lanes_r;
  lanes_t lanes_nxt;
  logic   take;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      lanes_nxt[k].zero = up_lanes[k].zero;
      if (!up_lanes[k].y[XY_W-1]) begin
        lanes_nxt[k].x   = up_lanes[k].x + (up_lanes[k].y >>> STAGE);
        lanes_nxt[k].y   = up_lanes[k].y - (up_lanes[k].x >>> STAGE);
        lanes_nxt[k].acc = up_lanes[k].acc + ANGLE;
      end else begin
        lanes_nxt[k].x   = up_lanes[k].x - (up_lanes[k].y >>> STAGE);
        lanes_nxt[k].y   = up_lanes[k].y + (up_lanes[k].x >>> STAGE);
        lanes_nxt[k].acc = up_lanes[k].acc - ANGLE;
      end
    end
  end

  assign take     = !valid_r || dn_ready;
  assign up_ready = take;
  assign dn_valid = valid_r;
  assign dn_lanes = lanes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && up_valid) begin
      lanes_r <= lanes_nxt;
    end
  end

endmodule

[hw/rtl/atilt_finish.sv]
`timescale 1ns / 1ps
// atilt_finish: rounding, saturation and output register
module atilt_finish #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  atilt_pkg::lanes_t               up_lanes,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output logic signed [atilt_pkg::ROLL_W-1:0] roll_angle,
  output logic signed [atilt_pkg::ROLL_W-1:0] pitch_angle,
  output logic signed [atilt_pkg::YAW_W-1:0]  yaw_angle
);
  import atilt_pkg::*;

  localparam int   SH      = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam acc_t HALF    = acc_t'(longint'(1) <<< (SH - 1));
  localparam acc_t OFF_TILT = deg_units(-90);
  localparam acc_t OFF_YAW  = deg_units(0);
  localparam acc_t TILT_LO = acc_t'(longint'(-270) * (longint'(1) <<< ANGLE_FRAC_BITS));
  localparam acc_t TILT_HI = acc_t'(longint'(90) * (longint'(1) <<< ANGLE_FRAC_BITS));
  localparam acc_t YAW_LO  = acc_t'(longint'(-180) * (longint'(1) <<< ANGLE_FRAC_BITS));
  localparam acc_t YAW_HI  = acc_t'(longint'(180) * (longint'(1) <<< ANGLE_FRAC_BITS));

  logic                     valid_r;
  logic signed [ROLL_W-1:0] roll_r;
  logic signed [ROLL_W-1:0] pitch_r;
  logic signed [YAW_W-1:0]  yaw_r;
  acc_t                     roll_nxt;
  acc_t                     pitch_nxt;
  acc_t                     yaw_nxt;
  logic                     take;

  function automatic acc_t round_sat(lane_t l, acc_t off, acc_t lo, acc_t hi);
    acc_t a;
    acc_t v;
    a = l.zero ? off : l.acc;
    v = (a + HALF) >>> SH;
    if (v < lo) begin
      v = lo;
    end else if (v > hi) begin
      v = hi;
    end
    return v;
  endfunction

  always_comb begin
    roll_nxt  = round_sat(up_lanes[LANE_ROLL], OFF_TILT, TILT_LO, TILT_HI);
    pitch_nxt = round_sat(up_lanes[LANE_PITCH], OFF_TILT, TILT_LO, TILT_HI);
    yaw_nxt   = round_sat(up_lanes[LANE_YAW], OFF_YAW, YAW_LO, YAW_HI);
  end

  assign take        = !valid_r || dn_ready;
  assign up_ready    = take;
  assign dn_valid    = valid_r;
  assign roll_angle  = roll_r;
  assign pitch_angle = pitch_r;
  assign yaw_angle   = yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && up_valid) begin
      roll_r  <= roll_nxt[ROLL_W-1:0];
      pitch_r <= pitch_nxt[ROLL_W-1:0];
      yaw_r   <= yaw_nxt[YAW_W-1:0];
    end
  end

endmodule

[hw/rtl/accel_tilt_angles_unit.sv]
`timescale 1ns / 1ps
// accel_tilt_angles_unit: roll, pitch and yaw from one accelerometer sample
//
//   channel | dir | handshake   | payload
//   in_ch   | in  | valid/ready | accel_x, accel_y, accel_z
//   out_ch  | out | valid/ready | roll_angle, pitch_angle, yaw_angle
//
// one request per cycle while the output is not stalled; registered in prep, the rotation cells and finish
// each rotation cell carries all three atan2 lanes and holds one request
// ready ripples back through the cells, so empty cells fill while the output is stalled
// reset clears the valid bits only; the pipeline is usable the cycle after reset
module accel_tilt_angles_unit #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 18
) (
  input logic            clk,
  input logic            rst_n,
  atilt_in_if.sink       in_ch,
  atilt_out_if.source    out_ch
);
  import atilt_pkg::*;

  localparam int NCELL = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  logic   vld [NCELL+1];
  logic   rdy [NCELL+1];
  lanes_t lanes [NCELL+1];

  atilt_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .accel_x  (in_ch.accel_x),
    .accel_y  (in_ch.accel_y),
    .accel_z  (in_ch.accel_z),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_lanes (lanes[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    atilt_cell #(.STAGE(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_lanes (lanes[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_lanes (lanes[i+1])
    );
  end

  atilt_finish #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (vld[NCELL]),
    .up_ready    (rdy[NCELL]),
    .up_lanes    (lanes[NCELL]),
    .dn_valid    (out_ch.valid),
    .dn_ready    (out_ch.ready),
    .roll_angle  (out_ch.roll_angle),
    .pitch_angle (out_ch.pitch_angle),
    .yaw_angle   (out_ch.yaw_angle)
  );

endmodule

[hw/rtl/atilt_checker.sv]
`timescale 1ns / 1ps
// atilt_checker: port-level assertions for the tilt angle unit, with its bind
module atilt_checker #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [atilt_pkg::ROLL_W-1:0] roll_angle,
  input logic signed [atilt_pkg::ROLL_W-1:0] pitch_angle,
  input logic signed [atilt_pkg::YAW_W-1:0]  yaw_angle
);
  import atilt_pkg::*;

  localparam int  TILT_LO  = -270 * (1 << ANGLE_FRAC_BITS);
  localparam int  TILT_HI  = 90 * (1 << ANGLE_FRAC_BITS);
  localparam int  YAW_LIM  = 180 * (1 << ANGLE_FRAC_BITS);
  localparam bit  WRAPS    = (ANGLE_FRAC_BITS > 7);

  // results are held while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(roll_angle)
      && $stable(pitch_angle) && $stable(yaw_angle))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the pipeline only refuses a sample when it is full behind a stalled result
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused with room in pipeline");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> WRAPS || (roll_angle >= TILT_LO && roll_angle <= TILT_HI
      && pitch_angle >= TILT_LO && pitch_angle <= TILT_HI))
    else $error("roll or pitch out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> WRAPS || (yaw_angle >= -YAW_LIM && yaw_angle <= YAW_LIM))
    else $error("yaw out of range");

endmodule

bind accel_tilt_angles_unit atilt_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_atilt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .roll_angle  (out_ch.roll_angle),
  .pitch_angle (out_ch.pitch_angle),
  .yaw_angle   (out_ch.yaw_angle)
);

[tb/accel_tilt_angles_unit_test.sv]
`timescale 1ns / 1ps
// accel_tilt_angles_unit_test: checks tilt angles from the unit against a bit-true cordic predictor
module accel_tilt_angles_unit_test;
  import atilt_pkg::*;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STAGES   = 18;
  localparam int N_DIRECTED      = 20;
  localparam int N_RANDOM        = 1800;
  localparam int PHASE_LEN       = 600;
  localparam int HOLD_CYCLES     = 64;
  localparam int DRAIN_CYCLES    = CORDIC_STAGES + 2 + 20;

  typedef struct packed {
    logic [ROLL_W-1:0] roll;
    logic [ROLL_W-1:0] pitch;
    logic [YAW_W-1:0]  yaw;
  } angles_t;

  typedef struct packed {
    sample_t           x;
    sample_t           y;
    sample_t           z;
    logic              typed;
    logic [ROLL_W-1:0] roll;
    logic [ROLL_W-1:0] pitch;
    logic [YAW_W-1:0]  yaw;
  } dir_row_t;

  // atan(2^-i) in nanodegrees
  localparam longint ATAN_NDEG [TABLE_LEN] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375, 64'sd1789910608, 64'sd895173710, 64'sd447614171,
    64'sd223810500, 64'sd111905677, 64'sd55952892, 64'sd27976453,
    64'sd13988227, 64'sd6994114, 64'sd3497057, 64'sd1748528,
    64'sd874264, 64'sd437132, 64'sd218566, 64'sd109283,
    64'sd54642, 64'sd27321, 64'sd13660, 64'sd6830
  };

  // all-zero sample: roll and pitch sit at -90 deg, yaw at 0
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 17'h1D300, 17'h1D300, 16'h0000},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '0, '0, '0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0, '0, '0},
    '{16'sh7FFF, 16'sd0, 16'sd0, 1'b0, '0, '0, '0},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0, '0, '0},
    '{16'sd0, 16'sh7FFF, 16'sd0, 1'b0, '0, '0, '0},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b0, '0, '0, '0},
    '{16'sd0, 16'sd0, 16'sh7FFF, 1'b0, '0, '0, '0},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b0, '0, '0, '0},
    '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0, '0, '0},
    '{16'sd1, 16'sd1, 16'sd1, 1'b0, '0, '0, '0},
    '{16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, '0, '0, '0},
    '{16'sh7FFF, 16'sh8000, 16'sd1, 1'b0, '0, '0, '0},
    '{-16'sd1, 16'sd0, 16'sd1, 1'b0, '0, '0, '0},
    '{16'sd0, -16'sd1, 16'sd0, 1'b0, '0, '0, '0},
    '{-16'sd5, 16'sd0, 16'sd0, 1'b0, '0, '0, '0},
    '{16'sd0, 16'sd0, -16'sd1, 1'b0, '0, '0, '0},
    '{16'sd1, 16'sh8000, 16'sh8000, 1'b0, '0, '0, '0},
    '{16'sd12345, -16'sd23456, 16'sd3210, 1'b0, '0, '0, '0},
    '{16'sh8000, -16'sd1, 16'sh7FFF, 1'b0, '0, '0, '0}
  };

  logic clk;
  logic rst_n;

  atilt_in_if  in_bus ();
  atilt_out_if out_bus ();

  accel_tilt_angles_unit #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STAGES  (CORDIC_STAGES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  angles_t pending_angles [$];
  int      errors        = 0;
  int      samples_sent  = 0;
  int      angles_seen   = 0;
  int      stall_cycles  = 0;
  int      src_idle_pct  = 31;
  int      dst_idle_pct  = 80;
  bit      hold_req      = 0;
  bit      hold_done     = 0;
  int      hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint atan_step_units(int i);
    return (ATAN_NDEG[i] * 64'sd16777216 + 64'sd500000000) / 64'sd1000000000;
  endfunction

  // atan2(num, den) in 2^-24 degree
  function automatic longint atan2_deg_units(longint num, longint den);
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint acc;
    acc = 0;
    if (num == 0 && den == 0) begin
      return 0;
    end
    x = den * 65536;
    y = num * 65536;
    if (x < 0) begin
      acc = (y >= 0) ? 180 * 64'sd16777216 : -180 * 64'sd16777216;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + atan_step_units(i);
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - atan_step_units(i);
      end
    end
    return acc;
  endfunction

  function automatic longint round_clamp(longint acc, longint lo_deg, longint hi_deg);
    int     sh;
    longint v;
    sh = ACC_FRAC - ANGLE_FRAC_BITS;
    v = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
    if (v < lo_deg * (64'sd1 <<< ANGLE_FRAC_BITS)) v = lo_deg * (64'sd1 <<< ANGLE_FRAC_BITS);
    if (v > hi_deg * (64'sd1 <<< ANGLE_FRAC_BITS)) v = hi_deg * (64'sd1 <<< ANGLE_FRAC_BITS);
    return v;
  endfunction

  function automatic angles_t tilt_angles_of(sample_t ax, sample_t ay, sample_t az);
    angles_t a;
    longint  r;
    longint  p;
    longint  w;
    r = round_clamp(atan2_deg_units(longint'(az), longint'(ax)) - 90 * 64'sd16777216, -270, 90);
    p = round_clamp(atan2_deg_units(longint'(az), longint'(ay)) - 90 * 64'sd16777216, -270, 90);
    w = round_clamp(atan2_deg_units(longint'(ax), longint'(ay)), -180, 180);
    a.roll  = r[ROLL_W-1:0];
    a.pitch = p[ROLL_W-1:0];
    a.yaw   = w[YAW_W-1:0];
    return a;
  endfunction

  function automatic sample_t rand_axis();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return sample_t'($urandom_range(0, 65535));
    if (pick < 70) return sample_t'($signed($urandom_range(0, 511)) - 256);
    if (pick < 85) begin
      case ($urandom_range(0, 6))
        0:       return 16'sh8000;
        1:       return 16'sh8001;
        2:       return -16'sd1;
        3:       return 16'sd1;
        4:       return 16'sh7FFE;
        5:       return 16'sh7FFF;
        default: return 16'sd0;
      endcase
    end
    return 16'sd0;
  endfunction

  task automatic flag_mismatch(string what, angles_t got, angles_t want);
    errors++;
    $display("mismatch %s: got roll %0d pitch %0d yaw %0d, want roll %0d pitch %0d yaw %0d",
             what, $signed(got.roll), $signed(got.pitch), $signed(got.yaw),
             $signed(want.roll), $signed(want.pitch), $signed(want.yaw));
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_sample(sample_t ax, sample_t ay, sample_t az, angles_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.accel_x <= ax;
    in_bus.accel_y <= ay;
    in_bus.accel_z <= az;
    @(posedge clk);
    while (!in_bus.ready) begin
      stall_cycles++;
      @(posedge clk);
    end
    pending_angles.push_back(want);
    samples_sent++;
    @(negedge clk);
  endtask

  initial begin : sample_source
    sample_t ax;
    sample_t ay;
    sample_t az;
    angles_t want;
    in_bus.valid   = 1'b0;
    in_bus.accel_x = '0;
    in_bus.accel_y = '0;
    in_bus.accel_z = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].typed) begin
        want.roll  = DIRECTED[i].roll;
        want.pitch = DIRECTED[i].pitch;
        want.yaw   = DIRECTED[i].yaw;
      end else begin
        want = tilt_angles_of(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z);
      end
      offer_sample(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z, want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == PHASE_LEN) begin
        src_idle_pct = 80;
        dst_idle_pct = 31;
      end
      if (n == 2 * PHASE_LEN) begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_req     = 1;
      end
      ax = rand_axis();
      ay = rand_axis();
      az = rand_axis();
      offer_sample(ax, ay, az, tilt_angles_of(ax, ay, az));
    end
    in_bus.valid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples (%0d directed incl. axis extremes and zero vectors, %0d random)",
             samples_sent, N_DIRECTED, N_RANDOM);
    $display("checked %0d angle sets, input held off %0d cycles by output back-pressure",
             angles_seen, stall_cycles);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : angle_sink
    angles_t got;
    angles_t want;
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
      end
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.roll  = out_bus.roll_angle;
        got.pitch = out_bus.pitch_angle;
        got.yaw   = out_bus.yaw_angle;
        angles_seen++;
        if (pending_angles.size() == 0) begin
          flag_mismatch("result with no request", got, '0);
        end else begin
          want = pending_angles.pop_front();
          if (got !== want) flag_mismatch("angles", got, want);
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
    end
  end

endmodule
